// File: hdl/assert_macros.svh
// Assertion macros shared by the shortest-arc quaternion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SARQ_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sarq assertion failed");
`define SARQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sarq assertion failed");
`else
`define SARQ_ASSERT(lbl, clk, rst, prop)
`define SARQ_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: hdl/sarq_pkg.sv
// Types, constants and rounding helper of the shortest-arc quaternion block.
package sarq_pkg;

   localparam int UNIT_FRAC     = 30;
   localparam int OUT_FRAC_BITS = 30;
   localparam int MARGIN_W      = 31;
   localparam int PROD_W        = 62;
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = 31'd1074;
   localparam logic [PROD_W-1:0]   NEAR_ZERO_SQ = 62'd1153476;

   localparam int OUT_SHIFT = UNIT_FRAC - OUT_FRAC_BITS;
   localparam logic [32:0] OUT_HALF = (OUT_SHIFT > 0) ? (33'd1 << (OUT_SHIFT - 1)) : 33'd0;
   localparam logic signed [31:0] ONE_Q30  = 32'sd1 <<< UNIT_FRAC;
   localparam logic signed [31:0] QUAT_ONE = 32'sd1 <<< OUT_FRAC_BITS;

   typedef enum logic [1:0] {
      CASE_GENERAL  = 2'd0,
      CASE_PARALLEL = 2'd1,
      CASE_OPPOSITE = 2'd2
   } case_type;

   typedef struct packed {
      logic signed [31:0] from_x;
      logic signed [31:0] from_y;
      logic signed [31:0] from_z;
      logic signed [31:0] to_x;
      logic signed [31:0] to_y;
      logic signed [31:0] to_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
      case_type           case_taken;
   } rsp_type;

   typedef struct packed {
      logic held;
      logic spare;
   } skid_status_type;

   function automatic logic signed [31:0] out_round(input logic signed [31:0] v);
      logic [31:0] m;
      logic [32:0] t;
      m = v[31] ? unsigned'(-v) : unsigned'(v);
      t = (33'(m) + OUT_HALF) >> OUT_SHIFT;
      return v[31] ? -signed'(t[31:0]) : signed'(t[31:0]);
   endfunction

endpackage

// File: hdl/sarq_req_if.sv
// Request channel: source and target vectors.
interface sarq_req_if;
   logic              valid;
   logic              ready;
   sarq_pkg::req_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// File: hdl/sarq_rsp_if.sv
// Response channel: quaternion and case code.
interface sarq_rsp_if;
   logic              valid;
   logic              ready;
   sarq_pkg::rsp_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// File: hdl/shortest_arc_quaternion.sv
// Top level of the shortest-arc quaternion pipeline.
//
//   channel   | direction | payload
//   req_chan  | in        | from_x/y/z, to_x/y/z, signed Q16.16
//   rsp_chan  | out       | quat_w/x/y/z signed Q1.30, case_taken
//   csr_*     | in        | parallel_margin, 31 bits, Q1.30
//
// One transfer per cycle in each direction while the output is not stalled. The path
// from input transfer to output register holds 85 register stages: two 40-stage
// scalers in series (square root two bits and divide two quotient bits per stage), three
// product and decision stages, one rounding stage and the output register.
// Reset clears all valid bits and sets the margin to 1074.
// A stalled output holds in the output register; one more result drops into the
// skid stage, then the whole pipeline holds and req_chan.ready falls.
`include "assert_macros.svh"
module shortest_arc_quaternion (
   input  logic                          clock,
   input  logic                          reset,
   sarq_req_if.sink                      req_chan,
   sarq_rsp_if.source                    rsp_chan,
   input  logic                          csr_we,
   input  logic [sarq_pkg::MARGIN_W-1:0] csr_wdata
);
   import sarq_pkg::*;

   logic [MARGIN_W-1:0] margin_ff, margin_in;
   logic                en;
   skid_status_type     skid_st;

   logic signed [31:0]  a_vec [3];
   logic signed [31:0]  b_vec [3];
   logic signed [31:0]  n1_vec [3];
   logic signed [31:0]  n2_vec [3];
   logic                n_valid;
   logic                c_valid;
   logic signed [63:0]  c_vec [4];
   case_type            c_case;
   logic                q_valid;
   logic signed [31:0]  q_vec [4];
   logic [1:0]          q_side;
   logic                f_v_ff;
   rsp_type             f_data_ff;
   rsp_type             f_data_c;

   assign margin_in = csr_we ? csr_wdata : margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
      end else begin
         margin_ff <= margin_in;
      end
   end

   assign en             = !skid_st.spare;
   assign req_chan.ready = en;

   always_comb begin
      a_vec[0] = req_chan.payload.from_x;
      a_vec[1] = req_chan.payload.from_y;
      a_vec[2] = req_chan.payload.from_z;
      b_vec[0] = req_chan.payload.to_x;
      b_vec[1] = req_chan.payload.to_y;
      b_vec[2] = req_chan.payload.to_z;
   end

   sarq_norm #(.LANES(3), .IN_W(32), .SIDE_W(1)) u_norm_from (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .in_vec   (a_vec),
      .in_side  (1'b0),
      .out_valid(n_valid),
      .out_vec  (n1_vec),
      .out_side ()
   );

   sarq_norm #(.LANES(3), .IN_W(32), .SIDE_W(1)) u_norm_to (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_chan.valid),
      .in_vec   (b_vec),
      .in_side  (1'b0),
      .out_valid(),
      .out_vec  (n2_vec),
      .out_side ()
   );

   sarq_combine u_combine (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (n_valid),
      .n1       (n1_vec),
      .n2       (n2_vec),
      .margin   (margin_ff),
      .out_valid(c_valid),
      .out_vec  (c_vec),
      .out_case (c_case)
   );

   sarq_norm #(.LANES(4), .IN_W(64), .SIDE_W(2)) u_norm_quat (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (c_valid),
      .in_vec   (c_vec),
      .in_side  (c_case),
      .out_valid(q_valid),
      .out_vec  (q_vec),
      .out_side (q_side)
   );

   always_comb begin
      f_data_c.case_taken = case_type'(q_side);
      unique case (case_type'(q_side))
         CASE_PARALLEL: begin
            f_data_c.quat_w = out_round(ONE_Q30);
            f_data_c.quat_x = '0;
            f_data_c.quat_y = '0;
            f_data_c.quat_z = '0;
         end
         CASE_OPPOSITE: begin
            f_data_c.quat_w = '0;
            f_data_c.quat_x = out_round(q_vec[1]);
            f_data_c.quat_y = out_round(q_vec[2]);
            f_data_c.quat_z = out_round(q_vec[3]);
         end
         default: begin
            f_data_c.quat_w = out_round(q_vec[0]);
            f_data_c.quat_x = out_round(q_vec[1]);
            f_data_c.quat_y = out_round(q_vec[2]);
            f_data_c.quat_z = out_round(q_vec[3]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else if (en) begin
         f_v_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_data_ff <= f_data_c;
      end
   end

   sarq_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_v_ff),
      .in_data  (f_data_ff),
      .out_valid(rsp_chan.valid),
      .out_data (rsp_chan.payload),
      .out_ready(rsp_chan.ready),
      .status   (skid_st)
   );

   `SARQ_ASSERT(a_spare_needs_held, clock, reset, skid_st.spare |-> skid_st.held)
   `SARQ_ASSERT(a_spare_after_stall, clock, reset,
                $rose(skid_st.spare) |-> $past(skid_st.held && !rsp_chan.ready))
   `SARQ_ASSERT(a_parallel_identity, clock, reset,
                (rsp_chan.valid && rsp_chan.payload.case_taken == CASE_PARALLEL) |->
                (rsp_chan.payload.quat_w == QUAT_ONE && rsp_chan.payload.quat_x == 0 &&
                 rsp_chan.payload.quat_y == 0 && rsp_chan.payload.quat_z == 0))
   `SARQ_ASSERT_NEXT(a_full_blocks_input, clock, reset, skid_st.spare && !rsp_chan.ready,
                     !req_chan.ready)

endmodule

// File: hdl/sarq_norm.sv
// Pipelined unit-length scaler: magnitude, normalize shift, square root, divide.
module sarq_norm #(
   parameter int LANES  = 4,
   parameter int IN_W   = 64,
   parameter int SIDE_W = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic signed [IN_W-1:0]   in_vec [LANES],
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic signed [31:0]       out_vec [LANES],
   output logic [SIDE_W-1:0]        out_side
);
   import sarq_pkg::*;

   localparam int PW     = $clog2(IN_W);
   localparam int UW     = UNIT_FRAC + 1;
   localparam int WW     = IN_W + UW;
   localparam int SS_W   = 2 * UW + $clog2(LANES);
   localparam int RT_W   = (SS_W + 1) / 2;
   localparam int SQ_ST  = (RT_W + 1) / 2;
   localparam int QB     = UNIT_FRAC + 1;
   localparam int NUM_W  = UW + UNIT_FRAC + 1;
   localparam int DIV_ST = (QB + 1) / 2;

   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic [IN_W-1:0]   mag1_ff [LANES];
   logic [IN_W-1:0]   mag2_ff [LANES];
   logic [IN_W-1:0]   mag3_ff [LANES];
   logic              neg1_ff [LANES];
   logic              neg2_ff [LANES];
   logic              neg3_ff [LANES];
   logic              neg4_ff [LANES];
   logic              neg5_ff [LANES];
   logic [SIDE_W-1:0] side1_ff, side2_ff, side3_ff, side4_ff, side5_ff;
   logic [IN_W-1:0]   max2_ff;
   logic [PW-1:0]     pos3_ff;
   logic [UW-1:0]     u4_ff [LANES];
   logic [UW-1:0]     u5_ff [LANES];
   logic [2*UW-1:0]   sq5_ff [LANES];

   logic              sqv_ff    [SQ_ST+1];
   logic [SS_W-1:0]   sqx_ff    [SQ_ST+1];
   logic [SS_W-1:0]   sqr_ff    [SQ_ST+1];
   logic [UW-1:0]     squ_ff    [SQ_ST+1][LANES];
   logic              sqneg_ff  [SQ_ST+1][LANES];
   logic [SIDE_W-1:0] sqside_ff [SQ_ST+1];

   logic              dvv_ff    [DIV_ST+1];
   logic [QB-1:0]     dvnum_ff  [DIV_ST+1][LANES];
   logic [RT_W-1:0]   dvrem_ff  [DIV_ST+1][LANES];
   logic [QB-1:0]     dvq_ff    [DIV_ST+1][LANES];
   logic              dvneg_ff  [DIV_ST+1][LANES];
   logic [RT_W-1:0]   dvden_ff  [DIV_ST+1];
   logic [SIDE_W-1:0] dvside_ff [DIV_ST+1];

   logic              out_v_ff;
   logic signed [31:0] out_vec_ff [LANES];
   logic [SIDE_W-1:0] out_side_ff;

   logic [IN_W-1:0]   mx_c;
   logic [PW-1:0]     pos_c;
   logic [WW-1:0]     wide_c [LANES];
   logic [SS_W-1:0]   ss_c;
   logic [RT_W-1:0]   nrm_c;
   logic [NUM_W-1:0]  num_c [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         sqv_ff[0] <= 1'b0;
         dvv_ff[0] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         sqv_ff[0] <= v5_ff;
         dvv_ff[0] <= sqv_ff[SQ_ST];
         out_v_ff <= dvv_ff[DIV_ST];
      end
   end

   always_comb begin
      mx_c = '0;
      for (int i = 0; i < LANES; i++) begin
         if (mag1_ff[i] > mx_c) mx_c = mag1_ff[i];
      end
   end

   always_comb begin
      pos_c = '0;
      for (int b = 0; b < IN_W; b++) begin
         if (max2_ff[b]) pos_c = PW'(b);
      end
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         wide_c[i] = {{UW{1'b0}}, mag3_ff[i]};
         if (pos3_ff >= PW'(UNIT_FRAC)) begin
            wide_c[i] = wide_c[i] >> (pos3_ff - PW'(UNIT_FRAC));
         end else begin
            wide_c[i] = wide_c[i] << (PW'(UNIT_FRAC) - pos3_ff);
         end
      end
   end

   always_comb begin
      ss_c = '0;
      for (int i = 0; i < LANES; i++) begin
         ss_c = ss_c + SS_W'(sq5_ff[i]);
      end
   end

   always_comb begin
      nrm_c = sqr_ff[SQ_ST][RT_W-1:0];
      for (int i = 0; i < LANES; i++) begin
         num_c[i] = (NUM_W'(squ_ff[SQ_ST][i]) << UNIT_FRAC) + NUM_W'(nrm_c >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < LANES; i++) begin
            neg1_ff[i] <= in_vec[i][IN_W-1];
            mag1_ff[i] <= in_vec[i][IN_W-1] ? unsigned'(-in_vec[i]) : unsigned'(in_vec[i]);
            mag2_ff[i] <= mag1_ff[i];
            neg2_ff[i] <= neg1_ff[i];
            mag3_ff[i] <= mag2_ff[i];
            neg3_ff[i] <= neg2_ff[i];
            u4_ff[i]   <= wide_c[i][UW-1:0];
            neg4_ff[i] <= neg3_ff[i];
            u5_ff[i]   <= u4_ff[i];
            neg5_ff[i] <= neg4_ff[i];
            sq5_ff[i]  <= u4_ff[i] * u4_ff[i];
            squ_ff[0][i]   <= u5_ff[i];
            sqneg_ff[0][i] <= neg5_ff[i];
            dvnum_ff[0][i] <= num_c[i][QB-1:0];
            dvrem_ff[0][i] <= RT_W'(num_c[i] >> QB);
            dvq_ff[0][i]   <= '0;
            dvneg_ff[0][i] <= sqneg_ff[SQ_ST][i];
            out_vec_ff[i]  <= dvneg_ff[DIV_ST][i] ? -signed'(32'(dvq_ff[DIV_ST][i]))
                                                  : signed'(32'(dvq_ff[DIV_ST][i]));
         end
         side1_ff <= in_side;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;
         side5_ff <= side4_ff;
         max2_ff  <= mx_c;
         pos3_ff  <= pos_c;
         sqx_ff[0]    <= ss_c;
         sqr_ff[0]    <= '0;
         sqside_ff[0] <= side5_ff;
         dvden_ff[0]  <= (nrm_c == '0) ? RT_W'(1) : nrm_c;
         dvside_ff[0] <= sqside_ff[SQ_ST];
         out_side_ff  <= dvside_ff[DIV_ST];
      end
   end

   for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
      logic [SS_W-1:0] x_c;
      logic [SS_W-1:0] r_c;
      logic [SS_W:0]   t_c;
      logic [SS_W:0]   bit_c;
      always_comb begin
         x_c   = sqx_ff[k];
         r_c   = sqr_ff[k];
         t_c   = '0;
         bit_c = '0;
         for (int j = 0; j < 2; j++) begin
            if (2 * k + j < RT_W) begin
               bit_c = (SS_W + 1)'(1) << (2 * (RT_W - 1 - (2 * k + j)));
               t_c   = {1'b0, r_c} + bit_c;
               if ({1'b0, x_c} >= t_c) begin
                  x_c = x_c - t_c[SS_W-1:0];
                  r_c = (r_c >> 1) + bit_c[SS_W-1:0];
               end else begin
                  r_c = r_c >> 1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sqv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sqv_ff[k+1] <= sqv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sqx_ff[k+1]    <= x_c;
            sqr_ff[k+1]    <= r_c;
            squ_ff[k+1]    <= squ_ff[k];
            sqneg_ff[k+1]  <= sqneg_ff[k];
            sqside_ff[k+1] <= sqside_ff[k];
         end
      end
   end

   for (genvar k = 0; k < DIV_ST; k++) begin : g_div
      logic [RT_W-1:0] rem_c [LANES];
      logic [QB-1:0]   q_c   [LANES];
      logic [RT_W:0]   s_c;
      always_comb begin
         s_c = '0;
         for (int i = 0; i < LANES; i++) begin
            rem_c[i] = dvrem_ff[k][i];
            q_c[i]   = dvq_ff[k][i];
            for (int j = 0; j < 2; j++) begin
               if (2 * k + j < QB) begin
                  s_c = {rem_c[i], dvnum_ff[k][i][QB - 1 - (2 * k + j)]};
                  if (s_c >= {1'b0, dvden_ff[k]}) begin
                     rem_c[i] = RT_W'(s_c - {1'b0, dvden_ff[k]});
                     q_c[i][QB - 1 - (2 * k + j)] = 1'b1;
                  end else begin
                     rem_c[i] = s_c[RT_W-1:0];
                  end
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dvv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dvv_ff[k+1] <= dvv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dvnum_ff[k+1]  <= dvnum_ff[k];
            dvrem_ff[k+1]  <= rem_c;
            dvq_ff[k+1]    <= q_c;
            dvneg_ff[k+1]  <= dvneg_ff[k];
            dvden_ff[k+1]  <= dvden_ff[k];
            dvside_ff[k+1] <= dvside_ff[k];
         end
      end
   end

   assign out_valid = out_v_ff;
   assign out_vec   = out_vec_ff;
   assign out_side  = out_side_ff;

endmodule

// File: hdl/sarq_combine.sv
// Dot and cross products, case decision and selection of the vector to scale.
module sarq_combine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [31:0]             n1 [3],
   input  logic signed [31:0]             n2 [3],
   input  logic [sarq_pkg::MARGIN_W-1:0]  margin,
   output logic                           out_valid,
   output logic signed [63:0]             out_vec [4],
   output sarq_pkg::case_type             out_case
);
   import sarq_pkg::*;

   localparam logic signed [35:0] ONE_D  = 36'sd1 <<< UNIT_FRAC;
   localparam logic signed [63:0] ONE_60 = 64'sd1 <<< (2 * UNIT_FRAC);
   localparam logic [63:0]        D_HALF = 64'd1 << (UNIT_FRAC - 1);

   logic                      c1_v_ff, c2_v_ff, c3_v_ff;
   logic signed [PROD_W-1:0]  pd_ff [3];
   logic signed [PROD_W-1:0]  pc_ff [6];
   logic [PROD_W-1:0]         psq_ff [2];
   logic signed [31:0]        n1a_ff [3];
   logic signed [31:0]        n1b_ff [3];
   logic signed [63:0]        dot_ff;
   logic signed [63:0]        g_ff [3];
   logic                      near_ff;
   logic signed [63:0]        vec_ff [4];
   case_type                  case_ff;

   logic [63:0]               dmag_c;
   logic signed [35:0]        dr_c;
   logic signed [35:0]        m_c;
   logic                      par_c, opp_c;
   logic signed [63:0]        vec_c [4];
   case_type                  case_c;

   function automatic logic signed [PROD_W-1:0] smul(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return signed'(p[PROD_W-1:0]);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_v_ff <= 1'b0;
         c2_v_ff <= 1'b0;
         c3_v_ff <= 1'b0;
      end else if (en) begin
         c1_v_ff <= in_valid;
         c2_v_ff <= c1_v_ff;
         c3_v_ff <= c2_v_ff;
      end
   end

   always_comb begin
      dmag_c = dot_ff[63] ? unsigned'(-dot_ff) : unsigned'(dot_ff);
      dr_c   = signed'(36'((dmag_c + D_HALF) >> UNIT_FRAC));
      if (dot_ff[63]) dr_c = -dr_c;
      if (dr_c > ONE_D) dr_c = ONE_D;
      if (dr_c < -ONE_D) dr_c = -ONE_D;
      m_c   = signed'(36'(margin));
      par_c = dr_c > ONE_D - m_c;
      opp_c = dr_c < -ONE_D + m_c;
      for (int i = 0; i < 4; i++) vec_c[i] = '0;
      priority if (par_c) begin
         case_c = CASE_PARALLEL;
      end else if (opp_c) begin
         case_c = CASE_OPPOSITE;
         if (near_ff) begin
            vec_c[1] = 64'(n1b_ff[2]);
            vec_c[3] = -64'(n1b_ff[0]);
         end else begin
            vec_c[2] = -64'(n1b_ff[2]);
            vec_c[3] = 64'(n1b_ff[1]);
         end
      end else begin
         case_c   = CASE_GENERAL;
         vec_c[0] = ONE_60 + dot_ff;
         vec_c[1] = g_ff[0];
         vec_c[2] = g_ff[1];
         vec_c[3] = g_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            pd_ff[i]  <= smul(n1[i], n2[i]);
            n1a_ff[i] <= n1[i];
            n1b_ff[i] <= n1a_ff[i];
         end
         pc_ff[0]  <= smul(n1[1], n2[2]);
         pc_ff[1]  <= smul(n1[2], n2[1]);
         pc_ff[2]  <= smul(n1[2], n2[0]);
         pc_ff[3]  <= smul(n1[0], n2[2]);
         pc_ff[4]  <= smul(n1[0], n2[1]);
         pc_ff[5]  <= smul(n1[1], n2[0]);
         psq_ff[0] <= unsigned'(smul(n1[1], n1[1]));
         psq_ff[1] <= unsigned'(smul(n1[2], n1[2]));
         dot_ff    <= 64'(pd_ff[0]) + 64'(pd_ff[1]) + 64'(pd_ff[2]);
         g_ff[0]   <= 64'(pc_ff[0]) - 64'(pc_ff[1]);
         g_ff[1]   <= 64'(pc_ff[2]) - 64'(pc_ff[3]);
         g_ff[2]   <= 64'(pc_ff[4]) - 64'(pc_ff[5]);
         near_ff   <= (psq_ff[0] + psq_ff[1]) < NEAR_ZERO_SQ;
         vec_ff    <= vec_c;
         case_ff   <= case_c;
      end
   end

   assign out_valid = c3_v_ff;
   assign out_vec   = vec_ff;
   assign out_case  = case_ff;

endmodule

// File: hdl/sarq_skid.sv
// Output register with a one-entry skid stage.
module sarq_skid (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  sarq_pkg::rsp_type          in_data,
   output logic                       out_valid,
   output sarq_pkg::rsp_type          out_data,
   input  logic                       out_ready,
   output sarq_pkg::skid_status_type  status
);
   import sarq_pkg::*;

   logic    held_ff, spare_ff;
   rsp_type held_data_ff, spare_data_ff;
   logic    take_c;

   assign take_c = in_valid && !spare_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= 1'b0;
         spare_ff <= 1'b0;
      end else if (!held_ff || out_ready) begin
         if (spare_ff) begin
            held_ff  <= 1'b1;
            spare_ff <= 1'b0;
         end else begin
            held_ff <= take_c;
         end
      end else if (take_c) begin
         spare_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!held_ff || out_ready) begin
         held_data_ff <= spare_ff ? spare_data_ff : in_data;
      end else if (take_c) begin
         spare_data_ff <= in_data;
      end
   end

   assign out_valid    = held_ff;
   assign out_data     = held_data_ff;
   assign status.held  = held_ff;
   assign status.spare = spare_ff;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for the shortest-arc quaternion block: directed table, random vectors, scoreboard.
module testbench;
   import sarq_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [MARGIN_W-1:0] csr_wdata = '0;
   logic [30:0] margin;
   bit failed = 1'b0;
   int quiet;
   int unsigned idle;
   rsp_type expected_quats[$];

   sarq_req_if req_chan();
   sarq_rsp_if rsp_chan();

   shortest_arc_quaternion u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
   end

   initial begin
      #200000000;
      $display("testbench: errors");
      $finish;
   end

   function automatic longint unsigned mag64(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic void unit_scale(input longint v[4], int n, output longint o[4]);
      longint unsigned u[4];
      longint unsigned m, ss, nrm, q;
      m = 0;
      ss = 0;
      for (int i = 0; i < 4; i++) begin
         o[i] = 0;
         u[i] = i < n ? mag64(v[i]) : 0;
         if (u[i] > m) m = u[i];
      end
      if (m == 0) return;
      while (m >= (64'd1 << 31)) begin
         m >>= 1;
         for (int i = 0; i < n; i++) u[i] >>= 1;
      end
      while (m < (64'd1 << 30)) begin
         m <<= 1;
         for (int i = 0; i < n; i++) u[i] <<= 1;
      end
      for (int i = 0; i < n; i++) ss += u[i] * u[i];
      nrm = root64(ss);
      for (int i = 0; i < n; i++) begin
         q = ((u[i] << UNIT_FRAC) + (nrm >> 1)) / nrm;
         o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic longint rshift_round(longint v, int sh);
      longint unsigned h, m;
      h = sh > 0 ? 64'd1 << (sh - 1) : 0;
      m = (mag64(v) + h) >> sh;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic rsp_type arc_quat(req_type r);
      longint a[4], b[4], n1[4], n2[4], q[4], ax[4], g[4];
      longint dot60, dot, one, mg;
      rsp_type o;
      one = 64'sd1 << UNIT_FRAC;
      mg = longint'(margin);
      a = '{r.from_x, r.from_y, r.from_z, 0};
      b = '{r.to_x, r.to_y, r.to_z, 0};
      unit_scale(a, 3, n1);
      unit_scale(b, 3, n2);
      dot60 = n1[0] * n2[0] + n1[1] * n2[1] + n1[2] * n2[2];
      dot = rshift_round(dot60, UNIT_FRAC);
      if (dot > one) dot = one;
      if (dot < -one) dot = -one;
      q = '{0, 0, 0, 0};
      if (dot > one - mg) begin
         o.case_taken = CASE_PARALLEL;
         q[0] = one;
      end else if (dot < -one + mg) begin
         o.case_taken = CASE_OPPOSITE;
         ax = '{0, -n1[2], n1[1], 0};
         if (n1[1] * n1[1] + n1[2] * n1[2] < longint'(NEAR_ZERO_SQ))
            ax = '{n1[2], 0, -n1[0], 0};
         unit_scale(ax, 3, g);
         q = '{0, g[0], g[1], g[2]};
      end else begin
         o.case_taken = CASE_GENERAL;
         g[0] = (64'sd1 << (2 * UNIT_FRAC)) + dot60;
         g[1] = n1[1] * n2[2] - n1[2] * n2[1];
         g[2] = n1[2] * n2[0] - n1[0] * n2[2];
         g[3] = n1[0] * n2[1] - n1[1] * n2[0];
         unit_scale(g, 4, q);
      end
      o.quat_w = 32'(rshift_round(q[0], UNIT_FRAC - OUT_FRAC_BITS));
      o.quat_x = 32'(rshift_round(q[1], UNIT_FRAC - OUT_FRAC_BITS));
      o.quat_y = 32'(rshift_round(q[2], UNIT_FRAC - OUT_FRAC_BITS));
      o.quat_z = 32'(rshift_round(q[3], UNIT_FRAC - OUT_FRAC_BITS));
      return o;
   endfunction

   task automatic set_margin(logic [30:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      margin = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (expected_quats.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic send_vectors(req_type r);
      idle = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) idle = 0;
      if (idle != 0) begin
         req_chan.valid <= 1'b0;
         repeat (idle) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_quats.insert(expected_quats.size(), arc_quat(r));
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int style);
      unique case (style)
         0: return $urandom;
         1: return $signed($urandom_range(0, 4000)) - 2000;
         2: return $urandom_range(0, 3) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
         default: return 0;
      endcase
   endfunction

   task automatic random_phase(int count);
      req_type r;
      int style;
      for (int k = 0; k < count; k++) begin
         style = $urandom_range(0, 9);
         r.from_x = rand_coord(style % 3);
         r.from_y = rand_coord($urandom_range(0, 3));
         r.from_z = rand_coord(style % 3);
         if (style == 8) begin
            r.to_x = r.from_x + $signed($urandom_range(0, 8)) - 4;
            r.to_y = r.from_y;
            r.to_z = r.from_z;
         end else if (style == 9) begin
            r.to_x = -r.from_x;
            r.to_y = -r.from_y + $signed($urandom_range(0, 2)) - 1;
            r.to_z = -r.from_z;
         end else begin
            r.to_x = rand_coord($urandom_range(0, 3));
            r.to_y = rand_coord(style % 3);
            r.to_z = rand_coord($urandom_range(0, 2));
         end
         send_vectors(r);
      end
      req_chan.valid <= 1'b0;
   endtask

   typedef struct {
      req_type vec;
      bit known;
      rsp_type quat;
   } stim_row;

   localparam logic signed [31:0] MAXP = 32'sh7fff_ffff;
   localparam logic signed [31:0] MINN = 32'sh8000_0000;
   localparam logic signed [31:0] U1 = 32'sh0001_0000;
   stim_row directed[$];

   initial begin
      rsp_type id, zero_gen;
      id = '{QUAT_ONE, 0, 0, 0, CASE_PARALLEL};
      zero_gen = '{0, 0, 0, 0, CASE_GENERAL};
      directed = '{
         '{'{U1, 0, 0, U1, 0, 0}, 1, id},
         '{'{MAXP, MAXP, MAXP, MAXP, MAXP, MAXP}, 1, id},
         '{'{MINN, MINN, MINN, MINN, MINN, MINN}, 1, id},
         '{'{U1, 0, 0, -U1, 0, 0}, 1, '{0, 0, 0, -QUAT_ONE, CASE_OPPOSITE}},
         '{'{0, U1, 0, 0, -U1, 0}, 0, zero_gen},
         '{'{MAXP, 0, 0, MINN, 0, 0}, 0, zero_gen},
         '{'{U1, 0, 0, 0, U1, 0}, 0, zero_gen},
         '{'{0, 0, 0, U1, 2, 3}, 0, zero_gen},
         '{'{1, 2, 3, 0, 0, 0}, 0, zero_gen},
         '{'{0, 0, 0, 0, 0, 0}, 0, zero_gen},
         '{'{-1, -1, -1, 1, 1, 1}, 0, zero_gen},
         '{'{MINN, MAXP, 5, -7, 0, MAXP}, 0, zero_gen},
         '{'{1, 0, 0, 1, 1, 0}, 0, zero_gen},
         '{'{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh1234_5678,
             32'shaaaa_aaaa, 32'sh5555_5555, 32'shedcb_a987}, 0, zero_gen}
      };
      margin = MARGIN_RESET;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) begin
         if (directed[i].known && arc_quat(directed[i].vec) != directed[i].quat) begin
            $display("%0t directed row %0d: table %p predictor %p", $time, i,
                     directed[i].quat, arc_quat(directed[i].vec));
            failed = 1'b1;
         end
         send_vectors(directed[i].vec);
      end
      req_chan.valid <= 1'b0;
      drain();
      set_margin(31'd0);
      directed.delete();
      send_vectors('{U1, 0, 0, -U1, 0, 0});
      send_vectors('{0, 0, 0, 0, 0, 0});
      random_phase(200);
      drain();
      set_margin(31'h7fff_ffff);
      send_vectors('{0, 0, 0, U1, 0, 0});
      random_phase(100);
      drain();
      set_margin(31'h4000_0000);
      send_vectors('{0, 0, 0, 0, 0, 0});
      send_vectors('{U1, 0, 0, -U1, 0, 0});
      random_phase(150);
      drain();
      set_margin(31'h2000_0000);
      random_phase(250);
      drain();
      set_margin(MARGIN_RESET);
      random_phase(500);
      drain();
      if (!failed)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

   always @(negedge clock) begin
      if (quiet > 0) begin
         quiet <= quiet - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.ready && rsp_chan.valid) begin
         if ($urandom_range(0, 2) == 0) begin
            quiet <= $urandom_range(0, 15);
            rsp_chan.ready <= 1'b0;
         end
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   initial quiet = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_quats.size() == 0) begin
            $display("%0t unexpected transfer: actual %p", $time, rsp_chan.payload);
            failed = 1'b1;
         end else begin
            want = expected_quats.pop_front();
            if (rsp_chan.payload.quat_w !== want.quat_w ||
                rsp_chan.payload.quat_x !== want.quat_x ||
                rsp_chan.payload.quat_y !== want.quat_y ||
                rsp_chan.payload.quat_z !== want.quat_z ||
                rsp_chan.payload.case_taken !== want.case_taken) begin
               $display("%0t mismatch: expected %p actual %p", $time, want,
                        rsp_chan.payload);
               failed = 1'b1;
            end
         end
      end
   end
endmodule
